// ===== rtl/mi_pkg.sv =====
// Package for the modular inverse block: working width, step bound,
// sequencer states and the request/response words of the divide unit.
// No dependencies.
package mi_pkg;

    // Working width of the Euclid datapath; port fields stay 32 bits
    localparam int WIDTH     = 32;
    localparam int FIELD_W   = 32;
    localparam int EXT_W     = 64;
    localparam int MAX_STEPS = (WIDTH * 3) / 2 + 2;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int CNT_W     = $clog2(WIDTH + 1);

    typedef logic [WIDTH-1:0]  word_t;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MOD,
        S_OUT
    } mi_state_t;

    // Request to the shared divide unit
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
        word_t scale;
    } div_req_t;

    // Response from the shared divide unit
    typedef struct packed {
        logic  done;
        word_t remainder;
        word_t product;
    } div_rsp_t;

endpackage

// ===== rtl/mi_divunit.sv =====
// Shared restoring divide unit, one quotient bit per cycle, MSB first.
// Alongside it builds quotient * scale by shift-and-add. Uses mi_pkg.
module mi_divunit
    import mi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic  busy_reg,  busy_next;
    logic  done_reg,  done_next;
    cnt_t  cnt_reg,   cnt_next;
    word_t dvd_reg,   dvd_next;
    word_t dsr_reg,   dsr_next;
    word_t scale_reg, scale_next;
    word_t rem_reg,   rem_next;
    word_t acc_reg,   acc_next;

    logic [WIDTH:0]   partial;
    logic [WIDTH+1:0] diff;
    logic             qbit;

    // One trial subtraction per cycle
    assign partial = {rem_reg, dvd_reg[WIDTH-1]};
    assign diff    = {1'b0, partial} - {2'b00, dsr_reg};
    assign qbit    = ~diff[WIDTH+1];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        scale_next = scale_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = cnt_t'(WIDTH);
            dvd_next   = req.dividend;
            dsr_next   = req.divisor;
            scale_next = req.scale;
            rem_next   = '0;
            acc_next   = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            rem_next = qbit ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
            // Horner form of quotient * scale; prefixes never exceed the final value
            acc_next = {acc_reg[WIDTH-2:0], 1'b0} + (qbit ? scale_reg : '0);
            cnt_next = cnt_reg - cnt_t'(1);
            if (cnt_reg == cnt_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath words
    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        dsr_reg   <= dsr_next;
        scale_reg <= scale_next;
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;
    assign rsp.product   = acc_reg;

    // Checks
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divide unit done held for more than one cycle");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < dsr_reg)
        else $error("divide unit remainder not below divisor");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divide unit started while busy");

endmodule

// ===== rtl/modular_inverse.sv =====
// Modular inverse by the extended Euclidean algorithm: sequencer and
// Euclid registers, driving the shared divide unit. Uses mi_pkg, mi_divunit.
//
// Usage: drive operand_value and modulus and raise start; the word is taken
// at a rising edge where start is high and busy is low. busy stays high
// until the result has been shown. The result word appears on inverse,
// has_inverse and common_divisor for exactly one cycle, marked by done;
// the receiver cannot stall it, so it must take it in that cycle.
// Each Euclid step runs one pass of the bit-serial divider. When an inverse
// exists, a final reduction pass of the coefficient follows; a zero modulus
// skips the divider. The longest chain comes from consecutive Fibonacci
// operands (46 steps at WIDTH = 32). The one divide unit is the limit: one
// item at a time.
// A zero modulus gives common_divisor = operand_value and no inverse; when
// no inverse exists the inverse field is 0. Reset returns the block to
// idle with busy and done low; no clearing pass is needed.
module modular_inverse
    import mi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FIELD_W-1:0]  operand_value,
    input  logic [FIELD_W-1:0]  modulus,
    output logic                done,
    output logic [FIELD_W-1:0]  inverse,
    output logic                has_inverse,
    output logic [FIELD_W-1:0]  common_divisor
);

    mi_state_t state_reg, state_next;

    word_t rp_reg,  rp_next;
    word_t rc_reg,  rc_next;
    word_t tp_reg,  tp_next;
    word_t tc_reg,  tc_next;
    word_t mod_reg, mod_next;
    logic  par_reg, par_next;
    step_t step_reg, step_next;

    logic [FIELD_W-1:0] inv_reg, inv_next;
    logic               found_reg, found_next;
    logic [FIELD_W-1:0] gcd_reg, gcd_next;

    div_req_t req;
    div_rsp_t rsp;

    logic [EXT_W-1:0] val_ext, mod_ext, g_ext, inv_ext;
    word_t            inv_w;
    logic             is_found;

    // Input fields cut or widened to the working width
    assign val_ext = {{(EXT_W-FIELD_W){1'b0}}, operand_value};
    assign mod_ext = {{(EXT_W-FIELD_W){1'b0}}, modulus};
    assign g_ext   = EXT_W'(rp_reg);
    assign is_found = (rp_reg == word_t'(1)) && (mod_reg != '0);

    // Sign fix-up of the reduced coefficient
    assign inv_w   = (par_reg && (rsp.remainder != '0))
                     ? (mod_reg - rsp.remainder) : rsp.remainder;
    assign inv_ext = EXT_W'(inv_w);

    mi_divunit u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        rp_next    = rp_reg;
        rc_next    = rc_reg;
        tp_next    = tp_reg;
        tc_next    = tc_reg;
        mod_next   = mod_reg;
        par_next   = par_reg;
        step_next  = step_reg;
        inv_next   = inv_reg;
        found_next = found_reg;
        gcd_next   = gcd_reg;
        req.start    = 1'b0;
        req.dividend = rp_reg;
        req.divisor  = rc_reg;
        req.scale    = tc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rp_next    = val_ext[WIDTH-1:0];
                    rc_next    = mod_ext[WIDTH-1:0];
                    mod_next   = mod_ext[WIDTH-1:0];
                    tp_next    = word_t'(1);
                    tc_next    = '0;
                    par_next   = 1'b0;
                    step_next  = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((rc_reg == '0) || (step_reg == step_t'(MAX_STEPS)))
                begin
                    gcd_next   = g_ext[FIELD_W-1:0];
                    found_next = is_found;
                    inv_next   = '0;
                    if (is_found)
                    begin
                        // reduce the final coefficient modulo the modulus
                        req.start    = 1'b1;
                        req.dividend = tp_reg;
                        req.divisor  = mod_reg;
                        req.scale    = '0;
                        state_next   = S_MOD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    req.start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rsp.done)
                begin
                    rp_next    = rc_reg;
                    rc_next    = rsp.remainder;
                    tp_next    = tc_reg;
                    tc_next    = tp_reg + rsp.product;
                    par_next   = ~par_reg;
                    step_next  = step_reg + step_t'(1);
                    state_next = S_CHECK;
                end
            end
            S_MOD:
            begin
                if (rsp.done)
                begin
                    inv_next   = inv_ext[FIELD_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            par_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            par_reg   <= par_next;
        end
    end

    // Euclid and result words
    always_ff @(posedge clk)
    begin
        rp_reg    <= rp_next;
        rc_reg    <= rc_next;
        tp_reg    <= tp_next;
        tc_reg    <= tc_next;
        mod_reg   <= mod_next;
        inv_reg   <= inv_next;
        found_reg <= found_next;
        gcd_reg   <= gcd_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_OUT);
    assign inverse        = inv_reg;
    assign has_inverse    = found_reg;
    assign common_divisor = gcd_reg;

    // Checks
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    a_found_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && has_inverse) |-> (common_divisor == FIELD_W'(1)))
        else $error("inverse flagged with divisor other than one");

    a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && has_inverse) |-> (EXT_W'(inv_reg) < EXT_W'(mod_reg)))
        else $error("inverse not reduced below modulus");

    a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (req.divisor != '0))
        else $error("divide unit started with zero divisor");

endmodule
